FILE: src/csds_pkg.sv
// Shared types and codes for the circular-scan disk request scheduler.
package csds_pkg;

  // Opcode carried in the input tuser bit
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Flags that travel with the scan token from cell to cell
  typedef struct packed {
    logic active;      // token is in this stage
    logic have_above;  // a pending slot at or above the current track was found
    logic have_low;    // a pending slot was found at all
    logic have_free;   // an empty slot was found
  } scan_flags_t;

  // Slot write command broadcast to every cell
  typedef struct packed {
    logic en;   // write the addressed slot
    logic set;  // 1: park a request, 0: retire the slot
  } slot_wr_t;

endpackage

FILE: src/cscan_disk_request_scheduler_unit.sv
// Top level of the circular-scan disk request scheduler: control and the chain of slot cells.
//
// channel  direction  tdata (lowest bit up)                                    tuser
// s_axis   in         track, requester, zero pad to bytes                      opcode
// m_axis   out        grant_valid, grant_id, grant_track, disk_busy, rejected,  -
//                     zero pad to bytes
//
// Idle-disk request: the grant goes from the input into the result registers and then
// into the output register on retire. Other transactions walk a search token through the
// PENDING_DEPTH slot cells, one cell a cycle; the tail result is registered, then retired
// to the output register. The input opens again in the same cycle as the result turns valid.
// One transaction is in work at a time; a result waiting for m_axis_tready_i
// stalls only the retire of the next one. Reset clears the disk state and all slot valid bits.
module cscan_disk_request_scheduler_unit #(
  parameter int PENDING_DEPTH = 16,
  parameter int TRACK_WIDTH   = 16,
  parameter int OWNER_WIDTH   = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // track, requester, zero pad
  input  logic [((TRACK_WIDTH+OWNER_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // opcode
  input  logic                 s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // grant_valid, grant_id, grant_track, disk_busy, rejected, zero pad
  output logic [((TRACK_WIDTH+OWNER_WIDTH+3+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int IdxW      = $clog2(PENDING_DEPTH);
  localparam int OutFieldW = TRACK_WIDTH + OWNER_WIDTH + 3;
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;
  localparam int GidLsb    = 1;
  localparam int GtrkLsb   = 1 + OWNER_WIDTH;
  localparam int BusyBit   = 1 + OWNER_WIDTH + TRACK_WIDTH;
  localparam int RejBit    = BusyBit + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_q;

  // disk state
  logic                   busy_q;
  logic [TRACK_WIDTH-1:0] cur_track_q;

  // latched transaction
  logic                   in_op_q;
  logic [TRACK_WIDTH-1:0] in_track_q;
  logic [OWNER_WIDTH-1:0] in_owner_q;
  logic                   start_q;

  // finished result waiting for the output register
  logic                   res_gv_q, res_gv_d;
  logic [OWNER_WIDTH-1:0] res_gid_q, res_gid_d;
  logic [TRACK_WIDTH-1:0] res_gtrk_q, res_gtrk_d;
  logic                   res_busy_q, res_busy_d;
  logic                   res_rej_q, res_rej_d;
  csds_pkg::slot_wr_t     res_wr_q, res_wr_d;
  logic [IdxW-1:0]        res_idx_q, res_idx_d;

  // output register
  logic                   m_valid_q;
  logic [OutDataW-1:0]    m_data_q, m_data_d;

  logic s_accept, out_free, retire;
  logic [TRACK_WIDTH-1:0] s_track;
  logic [OWNER_WIDTH-1:0] s_owner;
  csds_pkg::slot_wr_t     cell_wr;

  // chain links; entry 0 feeds the first cell, the last entry is the tail
  csds_pkg::scan_flags_t  ch_flags       [PENDING_DEPTH+1];
  logic [IdxW-1:0]        ch_above_idx   [PENDING_DEPTH+1];
  logic [TRACK_WIDTH-1:0] ch_above_track [PENDING_DEPTH+1];
  logic [OWNER_WIDTH-1:0] ch_above_owner [PENDING_DEPTH+1];
  logic [IdxW-1:0]        ch_low_idx     [PENDING_DEPTH+1];
  logic [TRACK_WIDTH-1:0] ch_low_track   [PENDING_DEPTH+1];
  logic [OWNER_WIDTH-1:0] ch_low_owner   [PENDING_DEPTH+1];
  logic [IdxW-1:0]        ch_free_idx    [PENDING_DEPTH+1];

  assign s_track  = s_axis_tdata_i[TRACK_WIDTH-1:0];
  assign s_owner  = s_axis_tdata_i[TRACK_WIDTH +: OWNER_WIDTH];
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign retire   = (state_q == ST_DONE) && out_free;

  // Inject a fresh token at the head of the chain
  assign ch_flags[0]       = '{active: start_q, have_above: 1'b0, have_low: 1'b0,
                               have_free: 1'b0};
  assign ch_above_idx[0]   = '0;
  assign ch_above_track[0] = '0;
  assign ch_above_owner[0] = '0;
  assign ch_low_idx[0]     = '0;
  assign ch_low_track[0]   = '0;
  assign ch_low_owner[0]   = '0;
  assign ch_free_idx[0]    = '0;

  // Apply the slot write only as the result retires
  always_comb begin
    cell_wr     = res_wr_q;
    cell_wr.en  = res_wr_q.en && retire;
  end

  for (genvar gi = 0; gi < PENDING_DEPTH; gi++) begin : g_cell
    csds_cell #(
      .TRACK_WIDTH (TRACK_WIDTH),
      .OWNER_WIDTH (OWNER_WIDTH),
      .IDX_WIDTH   (IdxW),
      .CELL_IDX    (gi)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cur_track_i   (cur_track_q),
      .wr_i          (cell_wr),
      .wr_idx_i      (res_idx_q),
      .wr_track_i    (in_track_q),
      .wr_owner_i    (in_owner_q),
      .flags_i       (ch_flags[gi]),
      .above_idx_i   (ch_above_idx[gi]),
      .above_track_i (ch_above_track[gi]),
      .above_owner_i (ch_above_owner[gi]),
      .low_idx_i     (ch_low_idx[gi]),
      .low_track_i   (ch_low_track[gi]),
      .low_owner_i   (ch_low_owner[gi]),
      .free_idx_i    (ch_free_idx[gi]),
      .flags_o       (ch_flags[gi+1]),
      .above_idx_o   (ch_above_idx[gi+1]),
      .above_track_o (ch_above_track[gi+1]),
      .above_owner_o (ch_above_owner[gi+1]),
      .low_idx_o     (ch_low_idx[gi+1]),
      .low_track_o   (ch_low_track[gi+1]),
      .low_owner_o   (ch_low_owner[gi+1]),
      .free_idx_o    (ch_free_idx[gi+1])
    );
  end

  // Form the result from the tail of the chain (or from the input for an idle grant)
  always_comb begin
    res_gv_d   = 1'b0;
    res_gid_d  = '0;
    res_gtrk_d = '0;
    res_busy_d = busy_q;
    res_rej_d  = 1'b0;
    res_wr_d   = '0;
    res_idx_d  = '0;
    if (state_q == ST_IDLE) begin
      res_gv_d   = 1'b1;
      res_gid_d  = s_owner;
      res_gtrk_d = s_track;
      res_busy_d = 1'b1;
    end else if (in_op_q == csds_pkg::OP_REQUEST) begin
      res_busy_d = 1'b1;
      if (ch_flags[PENDING_DEPTH].have_free) begin
        res_wr_d.en  = 1'b1;
        res_wr_d.set = 1'b1;
        res_idx_d    = ch_free_idx[PENDING_DEPTH];
      end else begin
        res_rej_d = 1'b1;
      end
    end else if (ch_flags[PENDING_DEPTH].have_above) begin
      res_gv_d    = 1'b1;
      res_gid_d   = ch_above_owner[PENDING_DEPTH];
      res_gtrk_d  = ch_above_track[PENDING_DEPTH];
      res_busy_d  = 1'b1;
      res_wr_d.en = 1'b1;
      res_idx_d   = ch_above_idx[PENDING_DEPTH];
    end else if (ch_flags[PENDING_DEPTH].have_low) begin
      res_gv_d    = 1'b1;
      res_gid_d   = ch_low_owner[PENDING_DEPTH];
      res_gtrk_d  = ch_low_track[PENDING_DEPTH];
      res_busy_d  = 1'b1;
      res_wr_d.en = 1'b1;
      res_idx_d   = ch_low_idx[PENDING_DEPTH];
    end else begin
      res_busy_d = 1'b0;
    end
  end

  // Pack the output word
  always_comb begin
    m_data_d = '0;
    m_data_d[0] = res_gv_q;
    m_data_d[GidLsb +: OWNER_WIDTH]  = res_gid_q;
    m_data_d[GtrkLsb +: TRACK_WIDTH] = res_gtrk_q;
    m_data_d[BusyBit] = res_busy_q;
    m_data_d[RejBit]  = res_rej_q;
  end

  // Sequence one transaction: accept, scan, retire
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      busy_q      <= 1'b0;
      cur_track_q <= '0;
      res_wr_q    <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      start_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            if ((s_axis_tuser_i == csds_pkg::OP_REQUEST) && !busy_q) begin
              res_wr_q <= '0;
              state_q  <= ST_DONE;
            end else begin
              start_q <= 1'b1;
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (ch_flags[PENDING_DEPTH].active) begin
            res_wr_q <= res_wr_d;
            state_q  <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            busy_q <= res_busy_q;
            if (res_gv_q) begin
              cur_track_q <= res_gtrk_q;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // hold the result until the sink takes it
      if (retire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_op_q    <= s_axis_tuser_i;
      in_track_q <= s_track;
      in_owner_q <= s_owner;
    end
    if ((s_accept && (s_axis_tuser_i == csds_pkg::OP_REQUEST) && !busy_q) ||
        ((state_q == ST_SCAN) && ch_flags[PENDING_DEPTH].active)) begin
      res_gv_q   <= res_gv_d;
      res_gid_q  <= res_gid_d;
      res_gtrk_q <= res_gtrk_d;
      res_busy_q <= res_busy_d;
      res_rej_q  <= res_rej_d;
      res_idx_q  <= res_idx_d;
    end
    if (retire) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`ifndef ASSERT_OFF
  // the search token reaches the tail only while a scan is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_flags[PENDING_DEPTH].active |-> (state_q == ST_SCAN))
    else $error("scan token at chain tail outside of a scan");

  // a new result appears only from the retire step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised without a retired transaction");

  // a dropped request implies the disk stays held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q[RejBit]) |-> (m_data_q[BusyBit] && !m_data_q[0]))
    else $error("rejected result with idle disk or a grant");

  // the input side is closed while a transaction is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> !s_axis_tready_o)
    else $error("second transaction accepted during work");
`endif

endmodule

FILE: src/csds_cell.sv
// One pending-request slot plus one stage of the circular-scan search chain.
module csds_cell #(
  parameter int TRACK_WIDTH = 16,
  parameter int OWNER_WIDTH = 4,
  parameter int IDX_WIDTH   = 4,
  parameter int CELL_IDX    = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // current head position used by the above-or-equal compare
  input  logic [TRACK_WIDTH-1:0]  cur_track_i,
  // slot write command
  input  csds_pkg::slot_wr_t      wr_i,
  input  logic [IDX_WIDTH-1:0]    wr_idx_i,
  input  logic [TRACK_WIDTH-1:0]  wr_track_i,
  input  logic [OWNER_WIDTH-1:0]  wr_owner_i,
  // search token from the previous cell
  input  csds_pkg::scan_flags_t   flags_i,
  input  logic [IDX_WIDTH-1:0]    above_idx_i,
  input  logic [TRACK_WIDTH-1:0]  above_track_i,
  input  logic [OWNER_WIDTH-1:0]  above_owner_i,
  input  logic [IDX_WIDTH-1:0]    low_idx_i,
  input  logic [TRACK_WIDTH-1:0]  low_track_i,
  input  logic [OWNER_WIDTH-1:0]  low_owner_i,
  input  logic [IDX_WIDTH-1:0]    free_idx_i,
  // search token to the next cell
  output csds_pkg::scan_flags_t   flags_o,
  output logic [IDX_WIDTH-1:0]    above_idx_o,
  output logic [TRACK_WIDTH-1:0]  above_track_o,
  output logic [OWNER_WIDTH-1:0]  above_owner_o,
  output logic [IDX_WIDTH-1:0]    low_idx_o,
  output logic [TRACK_WIDTH-1:0]  low_track_o,
  output logic [OWNER_WIDTH-1:0]  low_owner_o,
  output logic [IDX_WIDTH-1:0]    free_idx_o
);

  localparam logic [IDX_WIDTH-1:0] MyIdx = IDX_WIDTH'(CELL_IDX);

  logic                   valid_q;
  logic [TRACK_WIDTH-1:0] track_q;
  logic [OWNER_WIDTH-1:0] owner_q;

  logic take_above, take_low, take_free;

  csds_pkg::scan_flags_t  flags_d, flags_q;
  logic [IDX_WIDTH-1:0]   above_idx_d, above_idx_q;
  logic [TRACK_WIDTH-1:0] above_track_d, above_track_q;
  logic [OWNER_WIDTH-1:0] above_owner_d, above_owner_q;
  logic [IDX_WIDTH-1:0]   low_idx_d, low_idx_q;
  logic [TRACK_WIDTH-1:0] low_track_d, low_track_q;
  logic [OWNER_WIDTH-1:0] low_owner_d, low_owner_q;
  logic [IDX_WIDTH-1:0]   free_idx_d, free_idx_q;

  // Hold the slot; update it only on an addressed write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_i.en && (wr_idx_i == MyIdx)) begin
      valid_q <= wr_i.set;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.set && (wr_idx_i == MyIdx)) begin
      track_q <= wr_track_i;
      owner_q <= wr_owner_i;
    end
  end

  // Compare this slot against the best so far; strict less keeps the lower slot on ties
  always_comb begin
    take_low   = valid_q && (!flags_i.have_low || (track_q < low_track_i));
    take_above = valid_q && (track_q >= cur_track_i) &&
                 (!flags_i.have_above || (track_q < above_track_i));
    take_free  = !valid_q && !flags_i.have_free;

    flags_d            = flags_i;
    flags_d.have_low   = flags_i.have_low | take_low;
    flags_d.have_above = flags_i.have_above | take_above;
    flags_d.have_free  = flags_i.have_free | take_free;

    above_idx_d   = take_above ? MyIdx   : above_idx_i;
    above_track_d = take_above ? track_q : above_track_i;
    above_owner_d = take_above ? owner_q : above_owner_i;
    low_idx_d     = take_low   ? MyIdx   : low_idx_i;
    low_track_d   = take_low   ? track_q : low_track_i;
    low_owner_d   = take_low   ? owner_q : low_owner_i;
    free_idx_d    = take_free  ? MyIdx   : free_idx_i;
  end

  // Advance the token to the next stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    above_idx_q   <= above_idx_d;
    above_track_q <= above_track_d;
    above_owner_q <= above_owner_d;
    low_idx_q     <= low_idx_d;
    low_track_q   <= low_track_d;
    low_owner_q   <= low_owner_d;
    free_idx_q    <= free_idx_d;
  end

  assign flags_o       = flags_q;
  assign above_idx_o   = above_idx_q;
  assign above_track_o = above_track_q;
  assign above_owner_o = above_owner_q;
  assign low_idx_o     = low_idx_q;
  assign low_track_o   = low_track_q;
  assign low_owner_o   = low_owner_q;
  assign free_idx_o    = free_idx_q;

endmodule

FILE: tb/tb_cscan_disk_request_scheduler_unit.sv
// Self-checking testbench for the circular-scan disk request scheduler.
`timescale 1ns / 100ps

module tb;

  localparam int PendDepth   = 16;
  localparam int TrackWidth  = 16;
  localparam int OwnerWidth  = 4;
  localparam int RandomCmds  = 500;
  localparam int DrainCycles = PendDepth + 16;

  // One command to the scheduler and one grant report from it
  typedef struct packed {
    logic                  op;
    logic [TrackWidth-1:0] track;
    logic [OwnerWidth-1:0] owner;
  } disk_cmd_t;

  typedef struct packed {
    logic                  grant_valid;
    logic [OwnerWidth-1:0] grant_id;
    logic [TrackWidth-1:0] grant_track;
    logic                  disk_busy;
    logic                  rejected;
  } grant_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // track, requester, zero pad
  logic [23:0] in_tdata = '0;
  // opcode
  logic        in_tuser = csds_pkg::OP_REQUEST;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  // grant_valid, grant_id, grant_track, disk_busy, rejected, zero pad
  logic [23:0] out_tdata;

  // Predictor state: the disk and its parked requests
  logic                  disk_held;
  logic [TrackWidth-1:0] head_track;
  logic                  park_valid [PendDepth];
  logic [TrackWidth-1:0] park_track [PendDepth];
  logic [OwnerWidth-1:0] park_owner [PendDepth];

  disk_cmd_t cmd_q[$];
  grant_t    grant_q[$];
  disk_cmd_t bus_cmd;
  int        cmd_total;
  int        grant_cnt;
  int        mismatch_cnt;
  int        gap_left;
  int        stall_left;
  bit        send_calm;
  bit        recv_calm;

  cscan_disk_request_scheduler_unit #(
    .PENDING_DEPTH(PendDepth),
    .TRACK_WIDTH  (TrackWidth),
    .OWNER_WIDTH  (OwnerWidth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(in_tvalid),
    .s_axis_tready_o(in_tready),
    .s_axis_tdata_i (in_tdata),
    .s_axis_tuser_i (in_tuser),
    .m_axis_tvalid_o(out_tvalid),
    .m_axis_tready_i(out_tready),
    .m_axis_tdata_o (out_tdata)
  );

  initial begin
    forever #5 clk_i = !clk_i;
  end

  // Apply one command to the predicted disk state and return the grant it causes
  function automatic grant_t schedule_step(disk_cmd_t cmd);
    grant_t g;
    int     above;
    int     lowest;
    int     pick;
    int     free_slot;
    g         = '0;
    above     = -1;
    lowest    = -1;
    free_slot = -1;
    if (cmd.op == csds_pkg::OP_REQUEST) begin
      if (!disk_held) begin
        disk_held     = 1'b1;
        head_track    = cmd.track;
        g.grant_valid = 1'b1;
        g.grant_id    = cmd.owner;
        g.grant_track = cmd.track;
      end else begin
        // park in the lowest free slot, drop when none is free
        for (int i = PendDepth - 1; i >= 0; i--) begin
          if (!park_valid[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          g.rejected = 1'b1;
        end else begin
          park_valid[free_slot] = 1'b1;
          park_track[free_slot] = cmd.track;
          park_owner[free_slot] = cmd.owner;
        end
      end
    end else begin
      // scan upward from the head, wrap to the lowest track; ties go to the lower slot
      for (int i = 0; i < PendDepth; i++) begin
        if (park_valid[i]) begin
          if (lowest < 0 || park_track[i] < park_track[lowest]) lowest = i;
          if (park_track[i] >= head_track &&
              (above < 0 || park_track[i] < park_track[above])) above = i;
        end
      end
      pick = (above >= 0) ? above : lowest;
      if (pick >= 0) begin
        park_valid[pick] = 1'b0;
        head_track       = park_track[pick];
        disk_held        = 1'b1;
        g.grant_valid    = 1'b1;
        g.grant_id       = park_owner[pick];
        g.grant_track    = park_track[pick];
      end else begin
        disk_held = 1'b0;
      end
    end
    g.disk_busy = disk_held;
    return g;
  endfunction

  // Wait before the next transaction; flip between calm and gappy stretches now and then
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
             grant_cnt, field, got, want);
    mismatch_cnt++;
  endtask

  task automatic push_cmd(logic op, int track, int owner);
    disk_cmd_t c;
    c.op    = op;
    c.track = track[TrackWidth-1:0];
    c.owner = owner[OwnerWidth-1:0];
    cmd_q.push_back(c);
  endtask

  // Driver: predict on each accepted transaction, then launch the next command after its gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tvalid <= 1'b0;
      gap_left  = 0;
      disk_held  = 1'b0;
      head_track = '0;
      for (int i = 0; i < PendDepth; i++) park_valid[i] = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        grant_q.push_back(schedule_step(bus_cmd));
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          bus_cmd = cmd_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {4'b0, bus_cmd.owner, bus_cmd.track};
          in_tuser  <= bus_cmd.op;
          gap_left  = draw_wait(send_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each grant against the oldest prediction, then stall for a while
  always @(posedge clk_i or negedge rst_ni) begin
    grant_t got;
    grant_t want;
    if (!rst_ni) begin
      out_tready <= 1'b1;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.grant_valid = out_tdata[0];
        got.grant_id    = out_tdata[4:1];
        got.grant_track = out_tdata[20:5];
        got.disk_busy   = out_tdata[21];
        got.rejected    = out_tdata[22];
        if (grant_q.size() == 0) begin
          $display("unexpected result %0d: 0x%0h", grant_cnt, out_tdata);
          mismatch_cnt++;
        end else begin
          want = grant_q.pop_front();
          if (got.grant_valid != want.grant_valid)
            report_mismatch("grant_valid", int'(got.grant_valid), int'(want.grant_valid));
          if (got.grant_id != want.grant_id)
            report_mismatch("grant_id", int'(got.grant_id), int'(want.grant_id));
          if (got.grant_track != want.grant_track)
            report_mismatch("grant_track", int'(got.grant_track), int'(want.grant_track));
          if (got.disk_busy != want.disk_busy)
            report_mismatch("disk_busy", int'(got.disk_busy), int'(want.disk_busy));
          if (got.rejected != want.rejected)
            report_mismatch("rejected", int'(got.rejected), int'(want.rejected));
        end
        grant_cnt++;
        stall_left = draw_wait(recv_calm);
        out_tready <= (stall_left == 0);
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= (stall_left == 0);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int  n;
    int  kind;
    int  len;
    int  trk;
    logic rel;
    grant_cnt    = 0;
    mismatch_cnt = 0;
    send_calm    = 1'b0;
    recv_calm    = 1'b0;

    // release to an idle disk, then grab the disk mid-range
    push_cmd(csds_pkg::OP_RELEASE, 'hFFFF, 15);
    push_cmd(csds_pkg::OP_REQUEST, 'h8000, 0);
    // fill every slot: extremes, ties with each other and with the head
    push_cmd(csds_pkg::OP_REQUEST, 'h0000, 15);
    push_cmd(csds_pkg::OP_REQUEST, 'hFFFF, 1);
    push_cmd(csds_pkg::OP_REQUEST, 'h8000, 2);
    push_cmd(csds_pkg::OP_REQUEST, 'h8000, 3);
    push_cmd(csds_pkg::OP_REQUEST, 'h7FFF, 4);
    push_cmd(csds_pkg::OP_REQUEST, 'h8001, 5);
    push_cmd(csds_pkg::OP_REQUEST, 'h0001, 6);
    push_cmd(csds_pkg::OP_REQUEST, 'hFFFE, 7);
    push_cmd(csds_pkg::OP_REQUEST, 'h5555, 8);
    push_cmd(csds_pkg::OP_REQUEST, 'hAAAA, 9);
    push_cmd(csds_pkg::OP_REQUEST, 'h0000, 10);
    push_cmd(csds_pkg::OP_REQUEST, 'hFFFF, 11);
    push_cmd(csds_pkg::OP_REQUEST, 'h1234, 12);
    push_cmd(csds_pkg::OP_REQUEST, 'hEDCB, 13);
    push_cmd(csds_pkg::OP_REQUEST, 'h0F0F, 14);
    push_cmd(csds_pkg::OP_REQUEST, 'hF0F0, 0);
    // store full: dropped
    push_cmd(csds_pkg::OP_REQUEST, 'hFFFF, 15);
    // serve the two ties at the head, then scan upward
    repeat (5) push_cmd(csds_pkg::OP_RELEASE, 'h0000, 0);

    // random bursts: fill-heavy, drain-heavy and mixed
    n = 0;
    while (n < RandomCmds) begin
      kind = $urandom_range(0, 2);
      len  = $urandom_range(4, 24);
      for (int k = 0; k < len; k++) begin
        case (kind)
          0:       rel = ($urandom_range(0, 9) < 2);
          1:       rel = ($urandom_range(0, 9) < 8);
          default: rel = ($urandom_range(0, 1) == 1);
        endcase
        case ($urandom_range(0, 3))
          0:       trk = $urandom_range(0, 65535);
          1:       trk = $urandom_range(0, 7);
          2:       trk = ($urandom_range(0, 1) == 1) ? 'hFFFF : 'h0000;
          default: trk = 'h8000 + $urandom_range(0, 15) - 8;
        endcase
        push_cmd(rel ? csds_pkg::OP_RELEASE : csds_pkg::OP_REQUEST, trk,
                 $urandom_range(0, 15));
        n++;
      end
    end
    cmd_total = cmd_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every command yields exactly one result
    while (grant_cnt < cmd_total) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (grant_q.size() != 0) begin
      $display("%0d expected results never arrived", grant_q.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("timeout after %0d results", grant_cnt);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: filelist.f
src/csds_pkg.sv
src/csds_cell.sv
src/cscan_disk_request_scheduler_unit.sv
tb/tb_cscan_disk_request_scheduler_unit.sv
